// File: src/msort_pkg.sv
// Shared constants and inter-module types for the merge sorter.
`timescale 1ns / 1ps

package msort_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_CAP       = 64;
  localparam int STORE_AW      = $clog2(MAX_CAP);
  localparam int DEF_MAX_ITEMS = 64;

  // Buffer port control from the sequencer to the two banks.
  typedef struct packed {
    logic                rd_bank;   // bank that holds the current source run
    logic [STORE_AW-1:0] rd_addr_a;
    logic [STORE_AW-1:0] rd_addr_b;
    logic                wr_en;
    logic                wr_bank;
    logic [STORE_AW-1:0] wr_addr;
    logic [VALUE_W-1:0]  wr_data;
  } ram_ctl_t;

  // Output register load request.
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } emit_t;

endpackage

// File: src/msort_ram.sv
// One buffer bank: single write port, two registered read ports.
`timescale 1ns / 1ps

module msort_ram #(
  parameter int DEPTH = msort_pkg::DEF_MAX_ITEMS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [msort_pkg::VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [msort_pkg::VALUE_W-1:0] rd_data_a,
  output logic [msort_pkg::VALUE_W-1:0] rd_data_b
);
  import msort_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: src/msort_seq.sv
// Sequencer: load, bottom-up merge passes through one shared compare, emit.
`timescale 1ns / 1ps

module msort_seq #(
  parameter int MAX_ITEMS = msort_pkg::DEF_MAX_ITEMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [msort_pkg::VALUE_W-1:0] in_value,
  input  logic                          in_last,
  output logic                          in_ready,
  input  logic [msort_pkg::VALUE_W-1:0] rd_a,
  input  logic [msort_pkg::VALUE_W-1:0] rd_b,
  input  logic                          out_taken,
  output msort_pkg::ram_ctl_t           ctl,
  output msort_pkg::emit_t              emit
);
  import msort_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int PW    = CNT_W + 1;   // holds lo + 2*width

  typedef enum logic [2:0] {
    S_LOAD, S_PASS, S_PAIR, S_RD, S_CMP, S_EMIT_RD, S_EMIT_LD, S_EMIT_WT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             src_r, src_nxt;
  logic [PW-1:0]    w_r, w_nxt;
  logic [PW-1:0]    lo_r, lo_nxt;
  logic [PW-1:0]    mid_r, mid_nxt;
  logic [PW-1:0]    hi_r, hi_nxt;
  logic [PW-1:0]    i_r, i_nxt;
  logic [PW-1:0]    j_r, j_nxt;
  logic [PW-1:0]    k_r, k_nxt;

  logic [PW-1:0] n;
  logic [PW-1:0] lo_w, lo_2w;
  logic          take_left;
  logic          emitting;
  logic          k_last;

  assign n         = PW'(count_r);
  assign lo_w      = lo_r + w_r;
  assign lo_2w     = lo_r + (w_r << 1);
  // take from the left run when strictly less or when the right run is used up; ties go right
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || ($signed(rd_a) < $signed(rd_b)));
  assign emitting  = (state_r == S_EMIT_RD) || (state_r == S_EMIT_LD) || (state_r == S_EMIT_WT);
  assign k_last    = ((k_r + PW'(1)) == n);
  assign in_ready  = (state_r == S_LOAD);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    src_nxt     = src_r;
    w_nxt       = w_r;
    lo_nxt      = lo_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;

    ctl.rd_bank   = src_r;
    ctl.rd_addr_a = emitting ? STORE_AW'(k_r) : STORE_AW'(i_r);
    ctl.rd_addr_b = STORE_AW'(j_r);
    ctl.wr_en     = 1'b0;
    ctl.wr_bank   = ~src_r;
    ctl.wr_addr   = STORE_AW'(k_r);
    ctl.wr_data   = take_left ? rd_a : rd_b;

    emit.load = 1'b0;
    emit.last = k_last;
    emit.ovf  = dropped_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_bank = 1'b0;
            ctl.wr_addr = STORE_AW'(count_r);
            ctl.wr_data = in_value;
            count_nxt   = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            w_nxt     = PW'(1);
            src_nxt   = 1'b0;
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (w_r >= n) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          lo_nxt    = '0;
          state_nxt = S_PAIR;
        end
      end
      S_PAIR: begin
        if (lo_r >= n) begin
          src_nxt   = ~src_r;
          w_nxt     = w_r << 1;
          state_nxt = S_PASS;
        end else begin
          mid_nxt   = (lo_w > n) ? n : lo_w;
          hi_nxt    = (lo_2w > n) ? n : lo_2w;
          i_nxt     = lo_r;
          j_nxt     = (lo_w > n) ? n : lo_w;
          k_nxt     = lo_r;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ctl.wr_en = 1'b1;
        if (take_left) begin
          i_nxt = i_r + PW'(1);
        end else begin
          j_nxt = j_r + PW'(1);
        end
        k_nxt = k_r + PW'(1);
        if ((k_r + PW'(1)) == hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = S_PAIR;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        emit.load = 1'b1;
        state_nxt = S_EMIT_WT;
      end
      S_EMIT_WT: begin
        if (out_taken) begin
          if (k_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            k_nxt     = k_r + PW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      src_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      src_r     <= src_nxt;
    end
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

endmodule

// File: src/merge_sorter.sv
// Top level of the merge sorter: two buffer banks, sequencer and output register.
`timescale 1ns / 1ps

// Collects a set of signed 32-bit values, one beat per cycle, until a beat
// with in_tlast; then sorts them ascending and streams them out, tlast on the
// final value and tuser set on every value of a set that lost values to a
// full store (up to MAX_ITEMS are kept, later ones are dropped). in_tready is
// low from the last input beat until the last output beat is taken. Sorting
// runs ceil(log2 n) bottom-up merge passes through a single read-compare-write
// loop over two ping-pong banks: per value moved, a read and a compare-write
// state, per run pair a setup state, per pass a setup and an end of pass check,
// and a last pass check to finish. Each value leaves through a bank read, a
// register load and a beat that waits for out_tready, before the next is read.
// No clearing pass: only entries written for the current set are ever used.

module merge_sorter #(
  parameter int MAX_ITEMS = msort_pkg::DEF_MAX_ITEMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [msort_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic                          in_tlast,   // last_item
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [msort_pkg::VALUE_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic                          out_tlast,  // end_of_set
  output logic                          out_tuser   // [0] overflow
);
  import msort_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  ram_ctl_t           ctl;
  emit_t              emit;
  logic [VALUE_W-1:0] b0_a, b0_b, b1_a, b1_b;
  logic [VALUE_W-1:0] rd_a, rd_b;
  logic               out_taken;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_data_r;
  logic               out_last_r;
  logic               out_ovf_r;

  // bank 0 takes the loaded values; merge passes ping-pong between the banks
  msort_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_bank0 (
    .clk       (clk),
    .wr_en     (ctl.wr_en && !ctl.wr_bank),
    .wr_addr   (ctl.wr_addr[AW-1:0]),
    .wr_data   (ctl.wr_data),
    .rd_addr_a (ctl.rd_addr_a[AW-1:0]),
    .rd_addr_b (ctl.rd_addr_b[AW-1:0]),
    .rd_data_a (b0_a),
    .rd_data_b (b0_b)
  );

  msort_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_bank1 (
    .clk       (clk),
    .wr_en     (ctl.wr_en && ctl.wr_bank),
    .wr_addr   (ctl.wr_addr[AW-1:0]),
    .wr_data   (ctl.wr_data),
    .rd_addr_a (ctl.rd_addr_a[AW-1:0]),
    .rd_addr_b (ctl.rd_addr_b[AW-1:0]),
    .rd_data_a (b1_a),
    .rd_data_b (b1_b)
  );

  // source bank is fixed across a pass, so the read-data select lines up
  assign rd_a = ctl.rd_bank ? b1_a : b0_a;
  assign rd_b = ctl.rd_bank ? b1_b : b0_b;

  msort_seq #(.MAX_ITEMS(MAX_ITEMS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .out_taken (out_taken),
    .ctl       (ctl),
    .emit      (emit)
  );

  assign out_taken = out_valid_r && out_tready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data_r <= rd_a;
      out_last_r <= emit.last;
      out_ovf_r  <= emit.ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// File: src/msort_chk.sv
// Port-level checker for the merge sorter, bound to the top level.
`timescale 1ns / 1ps

module msort_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [msort_pkg::VALUE_W-1:0] in_tdata,
  input logic                          in_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [msort_pkg::VALUE_W-1:0] out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // the final beat of an input set closes the input side
  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still ready after last beat");

  // once the last result is taken the block loads again
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not ready after final result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind merge_sorter msort_chk u_msort_chk (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the merge sorter: directed and random sets, stalls on both sides.
`timescale 1ns / 1ps

module testbench;
  import msort_pkg::*;

  localparam int SET_CAP      = DEF_MAX_ITEMS;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int HOLD_AT_BEAT = 40;   // starts once this many sorted beats are out
  localparam int MAX_REPORTS  = 30;
  localparam int RANDOM_ITEMS = 210;

  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EDGES} value_mix_e;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               drain_first;  // hold this beat until all sorted beats are back
  } load_beat_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               ovf;
  } sorted_beat_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;
  logic               out_tlast;
  logic               out_tuser;

  merge_sorter #(.MAX_ITEMS(SET_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  load_beat_t   unsent_values[$];
  sorted_beat_t sorted_expect[$];

  // Sorter shadow: values of the set being collected and its drop flag.
  logic signed [VALUE_W-1:0] set_vals[$];
  logic set_dropped = 1'b0;

  int  errors        = 0;
  int  results_seen  = 0;
  int  sets_done     = 0;
  int  overflow_sets = 0;
  int  values_taken  = 0;
  bit  in_fired      = 1'b0;
  bit  out_fired     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Collect one accepted value; on the final one, sort the set and queue its beats.
  function automatic void take_value(logic [VALUE_W-1:0] v, logic last);
    logic signed [VALUE_W-1:0] key;
    sorted_beat_t sb;
    int i;
    int j;
    values_taken++;
    if (set_vals.size() < SET_CAP) set_vals.push_back(v);
    else set_dropped = 1'b1;
    if (!last) return;
    for (i = 1; i < set_vals.size(); i++) begin
      key = set_vals[i];
      j = i - 1;
      while (j >= 0 && set_vals[j] > key) begin
        set_vals[j + 1] = set_vals[j];
        j--;
      end
      set_vals[j + 1] = key;
    end
    for (i = 0; i < set_vals.size(); i++) begin
      sb.value = set_vals[i];
      sb.last  = (i == set_vals.size() - 1);
      sb.ovf   = set_dropped;
      sorted_expect.push_back(sb);
    end
    sets_done++;
    if (set_dropped) overflow_sets++;
    set_vals.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(value_mix_e mix);
    case (mix)
      MIX_NARROW: return $urandom_range(0, 15) - 8;  // lots of ties
      MIX_EDGES: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_value(logic [VALUE_W-1:0] v, logic last, logic drain);
    load_beat_t b;
    b.value       = v;
    b.last        = last;
    b.drain_first = drain;
    unsent_values.push_back(b);
  endfunction

  function automatic void queue_set(int n, value_mix_e mix, logic drain);
    int k;
    for (k = 0; k < n; k++)
      queue_value(pick_value(mix), k == n - 1, drain && k == 0);
  endfunction

  // Driver: new beat at the falling edge once the previous one was taken.
  int send_gap   = 0;
  int sent_count = 0;

  always @(negedge clk) begin
    load_beat_t nb;
    if (rst_n && !(in_tvalid && !in_fired)) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (unsent_values.size() > 0 &&
                   !(unsent_values[0].drain_first && sorted_expect.size() != 0)) begin
        nb = unsent_values.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nb.value;
        in_tlast  <= nb.last;
        sent_count++;
        // alternate stretches of back-to-back beats and random gaps
        send_gap = ((sent_count / 25) % 2) ? $urandom_range(0, 3) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls after beats in alternate stretches, plus one long hold-off mid-set.
  int recv_stall = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired)
        recv_stall = ((results_seen / 30) % 2 == 1) ? $urandom_range(0, 3) : 0;
      if (!hold_done && out_tvalid && results_seen >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted input beats, check each accepted sorted beat.
  always @(posedge clk) begin
    sorted_beat_t want;
    if (!rst_n) begin
      in_fired  <= 1'b0;
      out_fired <= 1'b0;
    end else begin
      in_fired  <= in_tvalid && in_tready;
      out_fired <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (sorted_expect.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected sorted beat: expected none, got value %0d last %0b ovf %0b",
                     $time, $signed(out_tdata), out_tlast, out_tuser);
        end else begin
          want = sorted_expect.pop_front();
          if (out_tdata !== want.value || out_tlast !== want.last || out_tuser !== want.ovf) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: beat %0d: expected value %0d last %0b ovf %0b, got %0d %0b %0b",
                       $time, results_seen, $signed(want.value), want.last, want.ovf,
                       $signed(out_tdata), out_tlast, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) take_value(in_tdata, in_tlast);
    end
  end

  // Stimulus and end of run.
  initial begin
    int rand_count;
    int n;
    int set_idx;
    // single value, the most negative
    queue_value(32'h8000_0000, 1'b1, 1'b0);
    // extremes mixed
    queue_value(32'h7fff_ffff, 1'b0, 1'b0);
    queue_value(32'h8000_0000, 1'b0, 1'b0);
    queue_value(32'h0000_0000, 1'b0, 1'b0);
    queue_value(32'hffff_ffff, 1'b0, 1'b0);
    queue_value(32'h0000_0001, 1'b1, 1'b0);
    // ties
    queue_value(32'd5, 1'b0, 1'b0);
    queue_value(32'd5, 1'b0, 1'b0);
    queue_value(-32'sd5, 1'b0, 1'b0);
    queue_value(32'd5, 1'b0, 1'b0);
    queue_value(-32'sd5, 1'b1, 1'b0);
    // descending then ascending runs
    for (int k = 3; k >= -2; k--) queue_value(k, k == -2, 1'b0);
    for (int k = 0; k < 4; k++) queue_value(32'h1000_0000 * k, k == 3, 1'b0);

    // exactly full store, then overflow with the final three values dropped
    queue_set(SET_CAP, MIX_FULL, 1'b0);
    queue_set(SET_CAP + 3, value_mix_e'($urandom_range(0, 2)), 1'b0);
    rand_count = unsent_values.size();
    set_idx = 0;
    while (rand_count < RANDOM_ITEMS) begin
      n = $urandom_range(1, 10);
      queue_set(n, value_mix_e'($urandom_range(0, 2)), set_idx == 3);
      rand_count += n;
      set_idx++;
    end

    @(posedge rst_n);
    do @(posedge clk);
    while (unsent_values.size() != 0 || in_tvalid || sorted_expect.size() != 0);
    repeat (50) @(posedge clk);

    $display("Covered %0d sets from %0d values (%0d overflowed), %0d sorted beats checked.",
             sets_done, values_taken, overflow_sets, results_seen);
    if (errors == 0 && sorted_expect.size() == 0 && set_vals.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d sorted beats still expected.", sorted_expect.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
